>>> hdl/sfl_pkg.sv
// ----------------------------------------------------------------------------
// sfl_pkg
// Shared constants, register indexes and lane control type of the flanger.
// ----------------------------------------------------------------------------
package sfl_pkg;

  localparam int DELAY_DEPTH_DEF    = 1024;
  localparam int LFO_INDEX_BITS_DEF = 13;
  localparam int SAMPLE_BITS_DEF    = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int PHASE_W = 32;
  localparam int SWEEP_W = 17;
  localparam int FB_W    = 15;
  localparam int MIX_W   = 16;
  localparam int FRAC_W  = 8;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd48660;
  localparam logic [SWEEP_W-1:0] SWEEP_RST      = 17'd87000;
  localparam logic [FB_W-1:0]    FB_RST         = 15'd0;
  localparam logic [MIX_W-1:0]   MIX_RST        = 16'd32768;
  localparam logic               STEREO_RST     = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_SWEEP_DEPTH   = 3'd1,
    REG_FEEDBACK_GAIN = 3'd2,
    REG_MIX_GAIN      = 3'd3,
    REG_STEREO_MODE   = 3'd4
  } cfg_reg_e;

  // Strobes for the sequencer steps that act on the lanes, seen by both channel lanes
  typedef struct packed {
    logic clear;
    logic load;
    logic cap_x1;
    logic interp;
    logic gain;
    logic commit;
  } lane_ctrl_t;

endpackage

>>> hdl/sfl_if.sv
// ----------------------------------------------------------------------------
// sfl_if
// Stream channels of the flanger: sample pair in, flanged pair out.
// ----------------------------------------------------------------------------
interface sfl_in_if #(
  parameter int SAMPLE_BITS = sfl_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfl_out_if #(
  parameter int SAMPLE_BITS = sfl_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

>>> hdl/sfl_ctrl.sv
// ----------------------------------------------------------------------------
// sfl_ctrl
// Register file, LFO, tap address generation and step sequencer.
// ----------------------------------------------------------------------------
module sfl_ctrl #(
  parameter int DELAY_DEPTH    = sfl_pkg::DELAY_DEPTH_DEF,
  parameter int LFO_INDEX_BITS = sfl_pkg::LFO_INDEX_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sfl_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [sfl_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output sfl_pkg::lane_ctrl_t                  lane_ctrl_o,
  output logic [$clog2(DELAY_DEPTH)-1:0]       rd_addr_o,
  output logic [$clog2(DELAY_DEPTH)-1:0]       wr_addr_o,
  output logic [sfl_pkg::FRAC_W-1:0]           frac_o,
  output logic [sfl_pkg::FB_W-1:0]             fb_gain_o,
  output logic [sfl_pkg::MIX_W-1:0]            mix_gain_o,
  output logic                                 stereo_o
);
  import sfl_pkg::*;

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int TW  = LFO_INDEX_BITS + 2;
  localparam int PRW = SWEEP_W + TW;
  localparam int DLW = PRW - LFO_INDEX_BITS;
  localparam int PW  = (DLW > AW + 8) ? DLW : AW + 8;
  localparam int XW  = AW + 9;

  localparam logic [PW-1:0] CLAMP   = PW'((DELAY_DEPTH - 1) * 256);
  localparam logic [XW-1:0] SPAN    = XW'(DELAY_DEPTH) << 8;
  localparam logic [AW-1:0] LAST_AD = AW'(DELAY_DEPTH - 1);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_ADDR   = 8'b0000_0100,
    ST_RD1    = 8'b0000_1000,
    ST_RD2    = 8'b0001_0000,
    ST_MIX    = 8'b0010_0000,
    ST_GAIN   = 8'b0100_0000,
    ST_COMMIT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [PHASE_W-1:0] phase_step_q;
  logic [SWEEP_W-1:0] sweep_q;
  logic [FB_W-1:0]    fb_q;
  logic [MIX_W-1:0]   mix_q;
  logic               stereo_q;

  logic [PHASE_W-1:0] phase_q;
  logic [AW-1:0]      wp_q, wp_next;
  logic [AW-1:0]      clr_q;
  logic               out_valid_q;

  logic [PRW-1:0]     prod_q;
  logic [AW-1:0]      p1_q, p2_q;
  logic [FRAC_W-1:0]  f_q;

  logic [LFO_INDEX_BITS-1:0] lfo_idx;
  logic [TW-1:0]             tri_t;
  logic [PW-1:0]             delay_raw, delay_c;
  logic [XW-1:0]             delay_x, wpx, pos_x;
  logic [AW-1:0]             p1_d;
  logic                      accept, commit_ok;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign commit_ok = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  // Triangle from the top phase bits; the falling half wraps 4N - 4i
  always_comb begin
    lfo_idx = phase_q[PHASE_W-1 -: LFO_INDEX_BITS];
    if (lfo_idx[LFO_INDEX_BITS-1]) begin
      tri_t = TW'(0) - {lfo_idx, 2'b00};
    end else begin
      tri_t = {lfo_idx, 2'b00};
    end
  end

  // Delay, clamp and read position behind the write pointer
  always_comb begin
    delay_raw = PW'(prod_q[PRW-1:LFO_INDEX_BITS]);
    delay_c   = (delay_raw > CLAMP) ? CLAMP : delay_raw;
    delay_x   = XW'(delay_c);
    wpx       = {1'b0, wp_q, 8'h00};
    if (delay_x > wpx) begin
      pos_x = wpx + SPAN - delay_x;
    end else begin
      pos_x = wpx - delay_x;
    end
    p1_d = pos_x[AW+7:8];
  end

  assign wp_next = (wp_q == LAST_AD) ? '0 : wp_q + AW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == LAST_AD) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_ADDR;
      ST_ADDR:   state_d = ST_RD1;
      ST_RD1:    state_d = ST_RD2;
      ST_RD2:    state_d = ST_MIX;
      ST_MIX:    state_d = ST_GAIN;
      ST_GAIN:   state_d = ST_COMMIT;
      ST_COMMIT: if (commit_ok) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      phase_step_q <= PHASE_STEP_RST;
      sweep_q      <= SWEEP_RST;
      fb_q         <= FB_RST;
      mix_q        <= MIX_RST;
      stereo_q     <= STEREO_RST;
      phase_q      <= '0;
      wp_q         <= '0;
      clr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_PHASE_STEP:    phase_step_q <= cfg_data_i[PHASE_W-1:0];
          REG_SWEEP_DEPTH:   sweep_q      <= cfg_data_i[SWEEP_W-1:0];
          REG_FEEDBACK_GAIN: fb_q         <= cfg_data_i[FB_W-1:0];
          REG_MIX_GAIN:      mix_q        <= cfg_data_i[MIX_W-1:0];
          REG_STEREO_MODE:   stereo_q     <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (accept) phase_q <= phase_q + phase_step_q;
      if (commit_ok) begin
        wp_q <= wp_next;
      end
      if (commit_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) prod_q <= PRW'(sweep_q) * PRW'(tri_t);
    if (state_q == ST_ADDR) begin
      p1_q <= p1_d;
      p2_q <= (p1_d == LAST_AD) ? '0 : p1_d + AW'(1);
      f_q  <= pos_x[7:0];
    end
  end

  always_comb begin
    lane_ctrl_o.clear  = (state_q == ST_CLEAR);
    lane_ctrl_o.load   = accept;
    lane_ctrl_o.cap_x1 = (state_q == ST_RD2);
    lane_ctrl_o.interp = (state_q == ST_MIX);
    lane_ctrl_o.gain   = (state_q == ST_GAIN);
    lane_ctrl_o.commit = commit_ok;
  end

  assign rd_addr_o   = (state_q == ST_RD1) ? p1_q : p2_q;
  assign wr_addr_o   = (state_q == ST_CLEAR) ? clr_q : wp_next;
  assign frac_o      = f_q;
  assign fb_gain_o   = fb_q;
  assign mix_gain_o  = mix_q;
  assign stereo_o    = stereo_q;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/sfl_lane.sv
// ----------------------------------------------------------------------------
// sfl_lane
// One channel: delay memory, interpolation, feedback and mix arithmetic.
// ----------------------------------------------------------------------------
module sfl_lane #(
  parameter int DELAY_DEPTH = sfl_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = sfl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sfl_pkg::lane_ctrl_t               ctrl_i,
  input  logic                              active_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  logic [$clog2(DELAY_DEPTH)-1:0]    rd_addr_i,
  input  logic [$clog2(DELAY_DEPTH)-1:0]    wr_addr_i,
  input  logic [sfl_pkg::FRAC_W-1:0]        frac_i,
  input  logic [sfl_pkg::FB_W-1:0]          fb_gain_i,
  input  logic [sfl_pkg::MIX_W-1:0]         mix_gain_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_o
);
  import sfl_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int IW   = SB + 10;
  localparam int ACCW = SB + 18;

  logic signed [SB-1:0] mem [DELAY_DEPTH];
  logic signed [SB-1:0] rd_q;
  logic signed [SB-1:0] in_q, x1_q, del_q, out_q;
  logic signed [ACCW-1:0] acc_fb_q, acc_mix_q;

  logic [FRAC_W:0]        w0;
  logic signed [IW-1:0]   ip0, ip1, isum;
  logic signed [ACCW-1:0] acc_fb_d, acc_mix_d;
  logic signed [SB-1:0]   fb_sat, mix_sat, wdata;
  logic                   we;
  logic                   commit_seen_q;

  function automatic logic signed [SB-1:0] sat_f(input logic signed [SB+2:0] v);
    logic [3:0] top;
    top = v[SB+2:SB-1];
    if (top == 4'b0000 || top == 4'b1111) begin
      return v[SB-1:0];
    end else if (v[SB+2]) begin
      return {1'b1, {(SB-1){1'b0}}};
    end else begin
      return {1'b0, {(SB-1){1'b1}}};
    end
  endfunction

  // Linear interpolation between the two taps, rounded then floored
  always_comb begin
    w0   = (FRAC_W+1)'(256) - {1'b0, frac_i};
    ip0  = IW'(x1_q) * IW'($signed({1'b0, w0}));
    ip1  = IW'(rd_q) * IW'($signed({2'b00, frac_i}));
    isum = ip0 + ip1 + IW'(128);
  end

  always_comb begin
    acc_fb_d  = (ACCW'(in_q) <<< 15) + ACCW'(del_q) * ACCW'($signed({1'b0, fb_gain_i}))
              + ACCW'(16384);
    acc_mix_d = (ACCW'(in_q) <<< 15) + ACCW'(del_q) * ACCW'($signed({1'b0, mix_gain_i}))
              + ACCW'(32768);
  end

  assign fb_sat  = sat_f(acc_fb_q[ACCW-1:15]);
  // carry the sign bit into the saturation input
  assign mix_sat = sat_f({acc_mix_q[ACCW-1], acc_mix_q[ACCW-1:16]});
  assign we      = ctrl_i.clear || (ctrl_i.commit && active_i);
  assign wdata   = ctrl_i.clear ? '0 : fb_sat;

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr_i] <= wdata;
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load)   in_q  <= sample_i;
    if (ctrl_i.cap_x1) x1_q  <= rd_q;
    if (ctrl_i.interp) del_q <= isum[SB+7:8];
    if (ctrl_i.gain) begin
      acc_fb_q  <= acc_fb_d;
      acc_mix_q <= acc_mix_d;
    end
    // drop the result of an idle channel to zero
    if (ctrl_i.commit) out_q <= active_i ? mix_sat : '0;
  end

  // first result marker: output reads zero until a word has been produced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      commit_seen_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      commit_seen_q <= 1'b1;
    end
  end

  assign sample_o = commit_seen_q ? out_q : '0;

endmodule

>>> hdl/stereo_flanger_core.sv
// ----------------------------------------------------------------------------
// stereo_flanger_core
// Stereo flanger: triangle LFO sweeping an interpolated delay per channel.
// ----------------------------------------------------------------------------
// Flow: a new word is taken only in the idle state, after the last commit;
//   commit registers the result word and waits while one is unaccepted.
//   Two reads and one write per word on each active single-read-port memory.
// Reset: a pass over all DELAY_DEPTH entries (1024 by default) zeroes both
//   delay memories; no word is taken meanwhile, register writes still are.
module stereo_flanger_core #(
  parameter int DELAY_DEPTH    = sfl_pkg::DELAY_DEPTH_DEF,
  parameter int LFO_INDEX_BITS = sfl_pkg::LFO_INDEX_BITS_DEF,
  parameter int SAMPLE_BITS    = sfl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfl_in_if.sink                         in_i,
  sfl_out_if.source                      out_o
);
  import sfl_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  lane_ctrl_t        lane_ctrl;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [FRAC_W-1:0] frac;
  logic [FB_W-1:0]   fb_gain;
  logic [MIX_W-1:0]  mix_gain;
  logic              stereo;
  logic              in_ready, out_valid;
  logic signed [SAMPLE_BITS-1:0] left_res, right_res;

  sfl_ctrl #(
    .DELAY_DEPTH    (DELAY_DEPTH),
    .LFO_INDEX_BITS (LFO_INDEX_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .lane_ctrl_o (lane_ctrl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .frac_o      (frac),
    .fb_gain_o   (fb_gain),
    .mix_gain_o  (mix_gain),
    .stereo_o    (stereo)
  );

  sfl_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .active_i   (1'b1),
    .sample_i   (in_i.left_in),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .frac_i     (frac),
    .fb_gain_i  (fb_gain),
    .mix_gain_i (mix_gain),
    .sample_o   (left_res)
  );

  sfl_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_lane_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (lane_ctrl),
    .active_i   (stereo),
    .sample_i   (in_i.right_in),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .frac_i     (frac),
    .fb_gain_i  (fb_gain),
    .mix_gain_i (mix_gain),
    .sample_o   (right_res)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.left_out  = left_res;
  assign out_o.right_out = right_res;

endmodule

>>> tb/stereo_flanger_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_flanger_checker
// Watches the config port and both sample channels, predicts every flanged
// pair from its own copy of the LFO, delay lines and registers, and compares
// each returned word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module stereo_flanger_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sfl_in_if                              in_mon_i,
  sfl_out_if                             out_mon_i,
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);
  import sfl_pkg::*;

  localparam int SW        = SAMPLE_BITS_DEF;
  localparam int DEPTH     = DELAY_DEPTH_DEF;
  localparam int IDX_W     = LFO_INDEX_BITS_DEF;
  localparam int PRINT_CAP = 40;

  localparam longint unsigned LFO_N     = 64'd1 << IDX_W;
  localparam longint unsigned SPAN      = longint'(DEPTH) << FRAC_W;
  localparam longint unsigned MAX_DELAY = longint'(DEPTH - 1) << FRAC_W;
  localparam longint          FRAC_ONE  = longint'(1) <<< FRAC_W;
  localparam longint          Q15_ONE   = 32768;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } sample_pair_t;

  logic [PHASE_W-1:0]   phase_step;
  logic [PHASE_W-1:0]   lfo_phase;
  logic [SWEEP_W-1:0]   sweep_depth;
  logic [FB_W-1:0]      fb_gain;
  logic [MIX_W-1:0]     mix_gain;
  logic                 stereo_on;
  logic signed [SW-1:0] left_line  [DEPTH];
  logic signed [SW-1:0] right_line [DEPTH];
  int unsigned          wr_ptr;

  sample_pair_t flanged_q [$];
  sample_pair_t want;
  int unsigned  result_no = 0;
  int unsigned  err_count = 0;

  assign fail_count_o = err_count;

  task automatic report_error(input string msg);
    if (err_count < PRINT_CAP) $display("%s", msg);
    err_count++;
  endtask

  function automatic logic signed [SW-1:0] clip(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (SW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[SW-1:0];
    if (v < lo) return lo[SW-1:0];
    return v[SW-1:0];
  endfunction

  // Linear interpolation between two taps, rounded half up
  function automatic longint blend(input longint near_s, input longint far_s,
                                   input longint frac);
    return (near_s * (FRAC_ONE - frac) + far_s * frac + (FRAC_ONE >>> 1)) >>> FRAC_W;
  endfunction

  function automatic sample_pair_t flange_pair(input logic signed [SW-1:0] l_in,
                                               input logic signed [SW-1:0] r_in);
    longint unsigned lfo_idx, tri_t, dly, pos, wp_l;
    int unsigned     tap_a, tap_b;
    longint          frac, in_l, in_r, del_l, del_r, fb_l, mix_l;
    sample_pair_t    res;
    lfo_idx   = lfo_phase[PHASE_W-1 -: IDX_W];
    lfo_phase = lfo_phase + phase_step;
    // tri + 1 scaled by LFO_N: rises on the first half, falls on the second
    tri_t = (lfo_idx < LFO_N / 2) ? 4 * lfo_idx : 4 * LFO_N - 4 * lfo_idx;
    dly   = (sweep_depth * tri_t) >> IDX_W;
    if (dly > MAX_DELAY) dly = MAX_DELAY;
    wp_l  = wr_ptr;
    pos   = ((wp_l << FRAC_W) + SPAN - dly) % SPAN;
    tap_a = 32'(pos >> FRAC_W);
    tap_b = (tap_a + 1) % DEPTH;
    frac  = pos % FRAC_ONE;
    in_l  = l_in;
    in_r  = r_in;
    fb_l  = fb_gain;
    mix_l = mix_gain;
    del_l = blend(left_line[tap_a], left_line[tap_b], frac);
    del_r = stereo_on ? blend(right_line[tap_a], right_line[tap_b], frac) : 0;
    wr_ptr = (wr_ptr + 1) % DEPTH;
    left_line[wr_ptr] = clip((in_l * Q15_ONE + fb_l * del_l + Q15_ONE / 2) >>> 15);
    res.left  = clip((in_l * Q15_ONE + mix_l * del_l + Q15_ONE) >>> 16);
    res.right = '0;
    // Mono: leave the right line untouched
    if (stereo_on) begin
      right_line[wr_ptr] = clip((in_r * Q15_ONE + fb_l * del_r + Q15_ONE / 2) >>> 15);
      res.right = clip((in_r * Q15_ONE + mix_l * del_r + Q15_ONE) >>> 16);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step  = PHASE_STEP_RST;
      sweep_depth = SWEEP_RST;
      fb_gain     = FB_RST;
      mix_gain    = MIX_RST;
      stereo_on   = STEREO_RST;
      lfo_phase   = '0;
      wr_ptr      = 0;
      for (int k = 0; k < DEPTH; k++) begin
        left_line[k]  = '0;
        right_line[k] = '0;
      end
      flanged_q.delete();
      pending_o <= 0;
    end else begin
      // Retire first, so a word cannot match an item taken on the same edge
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (flanged_q.size() == 0) begin
          report_error($sformatf("tb: word %0d returned with nothing outstanding",
                                 result_no));
        end else begin
          want = flanged_q.pop_front();
          if (out_mon_i.left_out !== want.left)
            report_error($sformatf("tb: word %0d left_out %0d, predicted %0d",
                                   result_no, out_mon_i.left_out, want.left));
          if (out_mon_i.right_out !== want.right)
            report_error($sformatf("tb: word %0d right_out %0d, predicted %0d",
                                   result_no, out_mon_i.right_out, want.right));
        end
        result_no++;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_PHASE_STEP:    phase_step  = cfg_data_i[PHASE_W-1:0];
          REG_SWEEP_DEPTH:   sweep_depth = cfg_data_i[SWEEP_W-1:0];
          REG_FEEDBACK_GAIN: fb_gain     = cfg_data_i[FB_W-1:0];
          REG_MIX_GAIN:      mix_gain    = cfg_data_i[MIX_W-1:0];
          REG_STEREO_MODE:   stereo_on   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready)
        flanged_q.push_back(flange_pair(in_mon_i.left_in, in_mon_i.right_in));
      pending_o <= flanged_q.size();
    end
  end

endmodule

>>> tb/stereo_flanger_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_flanger_core_tb
// Drives sample pairs and register settings into the flanger core with
// random gaps and back-pressure; a checker beside the core predicts and
// compares every flanged word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module stereo_flanger_core_tb;
  import sfl_pkg::*;

  localparam int SW              = SAMPLE_BITS_DEF;
  localparam int RAND_PHASES     = 9;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int TAIL_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam logic [SWEEP_W-1:0]   SWEEP_MAX       = '1;
  localparam logic [FB_W-1:0]      FB_MAX          = '1;
  localparam logic [MIX_W-1:0]     MIX_MAX         = '1;
  localparam logic [FB_W-1:0]      FB_NOMINAL_MAX  = 15'd32440;
  localparam logic [MIX_W-1:0]     MIX_UNITY       = 16'd32768;
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LIST = CFG_IDX_W'(REG_STEREO_MODE)
                                                     + CFG_IDX_W'(1);

  localparam logic signed [SW-1:0] CORNERS [8] = '{
    24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF,
    24'sh000001, 24'sh555555, 24'shAAAAAA, 24'sh00FF00
  };

  typedef struct packed {
    logic [PHASE_W-1:0] step;
    logic [SWEEP_W-1:0] sweep;
    logic [FB_W-1:0]    fb;
    logic [MIX_W-1:0]   mix;
    logic               stereo;
  } flanger_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           pending;
  int unsigned           fail_count;
  int unsigned           src_idle_pct  = 0;
  int unsigned           sink_idle_pct = 0;
  int unsigned           stuck_cycles  = 0;

  sfl_in_if  in_ch ();
  sfl_out_if out_ch ();

  stereo_flanger_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  stereo_flanger_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sink side: ready drops in bursts of random length
  initial begin : sink_side
    int unsigned hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(0, 9);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] s;
    case ($urandom_range(0, 9))
      0: s = CORNERS[$urandom_range(0, 7)];
      1, 2: begin
        s = SW'($urandom_range(0, 2047));
        s = s - SW'(1024);
      end
      default: s = SW'($urandom());
    endcase
    return s;
  endfunction

  function automatic flanger_cfg_t pick_cfg(input int kind);
    flanger_cfg_t c;
    c.step   = ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 32'h0040_0000);
    c.sweep  = SWEEP_W'($urandom_range(0, SWEEP_MAX));
    c.fb     = FB_W'($urandom_range(0, FB_MAX));
    c.mix    = MIX_W'($urandom_range(0, MIX_MAX));
    c.stereo = 1'($urandom_range(0, 1));
    case (kind)
      0: begin
        c.sweep  = SWEEP_MAX;
        c.fb     = FB_MAX;
        c.mix    = MIX_MAX;
        c.stereo = 1'b1;
      end
      1: begin
        c.step  = '0;
        c.sweep = '0;
        c.fb    = '0;
        c.mix   = '0;
      end
      2: begin
        c.step = '1;
        c.fb   = FB_NOMINAL_MAX;
        c.mix  = MIX_UNITY;
      end
      default: ;
    endcase
    return c;
  endfunction

  // Fill the bits above the register width with noise; the core must drop them
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= (width >= CFG_DATA_W) ? value : (value | (junk << width));
    @(posedge clk);
  endtask

  task automatic program_cfg(input flanger_cfg_t c, input bit spare_write);
    write_reg(REG_PHASE_STEP, c.step, PHASE_W);
    write_reg(REG_SWEEP_DEPTH, CFG_DATA_W'(c.sweep), SWEEP_W);
    write_reg(REG_FEEDBACK_GAIN, CFG_DATA_W'(c.fb), FB_W);
    write_reg(REG_MIX_GAIN, CFG_DATA_W'(c.mix), MIX_W);
    write_reg(REG_STEREO_MODE, CFG_DATA_W'(c.stereo), 1);
    if (spare_write)
      write_reg(REG_BEYOND_LIST + CFG_IDX_W'($urandom_range(0, 2)), $urandom(), CFG_DATA_W);
    cfg_we <= 1'b0;
  endtask

  task automatic push_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold the sender until every predicted word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    flanger_cfg_t cfg;
    bit           last;
    in_ch.valid    <= 1'b0;
    in_ch.left_in  <= '0;
    in_ch.right_in <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_PHASE_STEP;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Half-turn phase step: the LFO alternates between zero delay and the
    // clamped longest delay, with gains above nominal to force saturation
    src_idle_pct  = 30;
    sink_idle_pct = 10;
    cfg = '{step: 32'h8000_0000, sweep: SWEEP_MAX, fb: FB_MAX, mix: MIX_MAX, stereo: 1'b1};
    program_cfg(cfg, 1'b1);
    for (int k = 0; k < 14; k++)
      push_pair(CORNERS[k % 8], CORNERS[(3 * k + 1) % 8]);
    drain();

    // Mono with a frozen LFO and zero gains
    cfg = pick_cfg(1);
    cfg.stereo = 1'b0;
    program_cfg(cfg, 1'b0);
    for (int k = 0; k < 6; k++)
      push_pair(CORNERS[k], pick_sample());
    drain();

    cfg = pick_cfg(2);
    program_cfg(cfg, 1'b0);
    for (int k = 0; k < 5; k++)
      push_pair(CORNERS[7 - k], CORNERS[k + 2]);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      last = (ph == RAND_PHASES - 1);
      cfg  = pick_cfg(ph);
      case ($urandom_range(0, 2))
        0: src_idle_pct = 0;
        1: src_idle_pct = 25;
        default: src_idle_pct = 60;
      endcase
      case ($urandom_range(0, 2))
        0: sink_idle_pct = 0;
        1: sink_idle_pct = 6;
        default: sink_idle_pct = 15;
      endcase
      if (last) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      program_cfg(cfg, $urandom_range(0, 2) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (!last && $urandom_range(0, 199) == 0) drain();
        push_pair(pick_sample(), pick_sample());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/sfl_pkg.sv
hdl/sfl_if.sv
hdl/sfl_ctrl.sv
hdl/sfl_lane.sv
hdl/stereo_flanger_core.sv
tb/stereo_flanger_checker.sv
tb/stereo_flanger_core_tb.sv
